// ===== design/i2cmts_pkg.sv =====
package i2cmts_pkg;

    // operation codes
    localparam logic [2:0] OP_START_WRITE = 3'd0;
    localparam logic [2:0] OP_START_READ  = 3'd1;
    localparam logic [2:0] OP_BUS_EVENT   = 3'd2;
    localparam logic [2:0] OP_ERROR_EVENT = 3'd3;
    localparam logic [2:0] OP_CLEAR_ERROR = 3'd4;

    // event flag bit positions
    localparam int EV_SB    = 0;
    localparam int EV_ADDR  = 1;
    localparam int EV_ADD10 = 2;
    localparam int EV_TXE   = 3;
    localparam int EV_RXNE  = 4;
    localparam int EV_BTF   = 5;

    // error flag bit positions
    localparam int ER_BUS  = 0;
    localparam int ER_AF   = 1;
    localparam int ER_ARLO = 2;

    // error status bits
    localparam logic [3:0] ES_BUS       = 4'b0001;
    localparam logic [3:0] ES_DATA_NACK = 4'b0010;
    localparam logic [3:0] ES_ADDR_NACK = 4'b0100;
    localparam logic [3:0] ES_ARLO      = 4'b1000;

    // control codes for ACK, POS and buffer interrupt
    localparam logic [1:0] CTL_NONE = 2'd0;
    localparam logic [1:0] CTL_SET  = 2'd1;
    localparam logic [1:0] CTL_CLR  = 2'd2;

    // upper five bits of a 10-bit address header (11110xx r/w)
    localparam logic [4:0] HDR10_PREFIX = 5'b11110;

    // result queue depth
    localparam logic [1:0] OUT_DEPTH = 2'd2;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b00000000001,
        PH_T_SETUP   = 11'b00000000010,
        PH_T_START   = 11'b00000000100,
        PH_T_HDR10   = 11'b00000001000,
        PH_T_DATA    = 11'b00000010000,
        PH_R_SETUP   = 11'b00000100000,
        PH_R_START   = 11'b00001000000,
        PH_R_HDR10   = 11'b00010000000,
        PH_R_ADDR10  = 11'b00100000000,
        PH_R_RESTART = 11'b01000000000,
        PH_R_DATA    = 11'b10000000000
    } phase_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  target_address;
        logic        ten_bit_address;
        logic [15:0] transfer_length;
        logic [5:0]  event_flags;
        logic [2:0]  error_flags;
        logic [7:0]  data_byte;
        logic [7:0]  second_data_byte;
    } item_t;

    typedef struct packed {
        phase_t     phase;
        logic [9:0] target;
        logic       target_is_ten_bit;
        logic [3:0] error_bits;
    } ctx_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       request_start;
        logic       request_stop;
        logic [1:0] ack_control;
        logic [1:0] pos_control;
        logic [1:0] buffer_irq_control;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       done_res;
        logic [3:0] error_status;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        logic [1:0] space;
    } fifo_stat_t;

endpackage

// ===== design/i2cmts_step.sv =====
// One sequencer step: next state and up to two results for the held request.
module i2cmts_step #(
    parameter int LENGTH_WIDTH = 16
) (
    input  i2cmts_pkg::item_t           item,
    input  logic                        hold_errors,
    input  i2cmts_pkg::ctx_t            ctx_cur,
    input  logic [LENGTH_WIDTH-1:0]     length_cur,
    input  logic [LENGTH_WIDTH-1:0]     count_cur,
    output i2cmts_pkg::ctx_t            ctx_nxt,
    output logic [LENGTH_WIDTH-1:0]     length_nxt,
    output logic [LENGTH_WIDTH-1:0]     count_nxt,
    output i2cmts_pkg::res_t            res0,
    output i2cmts_pkg::res_t            res1,
    output logic                        two_res
);

    localparam int LW = LENGTH_WIDTH;
    localparam int CW = LENGTH_WIDTH + 3;

    always_comb begin
        i2cmts_pkg::phase_t    ph;
        logic [9:0]            tgt;
        logic                  ten;
        logic [3:0]            err;
        logic [LW-1:0]         len;
        logic [LW-1:0]         bc;
        logic [3:0]            status;
        logic [7:0]            hdr_w;
        logic [7:0]            hdr_r;

        ph     = ctx_cur.phase;
        tgt    = ctx_cur.target;
        ten    = ctx_cur.target_is_ten_bit;
        err    = ctx_cur.error_bits;
        len    = length_cur;
        bc     = count_cur;
        res0   = '0;
        res1   = '0;
        two_res = 1'b0;
        hdr_w  = {i2cmts_pkg::HDR10_PREFIX, tgt[9:8], 1'b0};
        hdr_r  = {i2cmts_pkg::HDR10_PREFIX, tgt[9:8], 1'b1};

        case (item.operation)
            i2cmts_pkg::OP_START_WRITE, i2cmts_pkg::OP_START_READ: begin
                if (hold_errors && (err != 4'd0)) begin
                    res0.done_res = 1'b1;   // refused
                end else begin
                    if (!hold_errors) begin
                        err = 4'd0;
                    end
                    tgt = item.target_address;
                    ten = item.ten_bit_address;
                    len = LW'(item.transfer_length);
                    bc  = '0;
                    ph  = (item.operation == i2cmts_pkg::OP_START_READ) ?
                          i2cmts_pkg::PH_R_SETUP : i2cmts_pkg::PH_T_SETUP;
                    res0.request_start = 1'b1;
                    hdr_w = {i2cmts_pkg::HDR10_PREFIX, tgt[9:8], 1'b0};
                    hdr_r = {i2cmts_pkg::HDR10_PREFIX, tgt[9:8], 1'b1};
                end
            end
            i2cmts_pkg::OP_BUS_EVENT: begin
                // start sent
                if (item.event_flags[i2cmts_pkg::EV_SB]) begin
                    if (ph == i2cmts_pkg::PH_T_SETUP) begin
                        ph = i2cmts_pkg::PH_T_START;
                        res0.send_valid = 1'b1;
                        res0.send_byte  = ten ? hdr_w : {tgt[6:0], 1'b0};
                    end else if (ph == i2cmts_pkg::PH_R_SETUP) begin
                        ph = i2cmts_pkg::PH_R_START;
                        res0.send_valid = 1'b1;
                        res0.send_byte  = ten ? hdr_w : {tgt[6:0], 1'b1};
                    end else if (ph == i2cmts_pkg::PH_R_ADDR10) begin
                        ph = i2cmts_pkg::PH_R_RESTART;
                        res0.send_valid = 1'b1;
                        res0.send_byte  = hdr_r;
                    end
                end
                // address sent
                if (item.event_flags[i2cmts_pkg::EV_ADDR]) begin
                    if (ph == i2cmts_pkg::PH_T_START || ph == i2cmts_pkg::PH_T_HDR10) begin
                        ph = i2cmts_pkg::PH_T_DATA;
                        res0.buffer_irq_control = i2cmts_pkg::CTL_SET;
                    end else if (ph == i2cmts_pkg::PH_R_START ||
                                 ph == i2cmts_pkg::PH_R_RESTART) begin
                        if (len == '0) begin
                            res0.request_stop = 1'b1;
                            res0.done_res     = 1'b1;
                            ph = i2cmts_pkg::PH_IDLE;
                        end else begin
                            if (len == LW'(2)) begin
                                res0.pos_control = i2cmts_pkg::CTL_SET;
                            end
                            if (len <= LW'(2)) begin
                                res0.ack_control = i2cmts_pkg::CTL_CLR;
                            end
                            ph = i2cmts_pkg::PH_R_DATA;
                            res0.buffer_irq_control = i2cmts_pkg::CTL_SET;
                        end
                    end else if (ph == i2cmts_pkg::PH_R_HDR10) begin
                        ph = i2cmts_pkg::PH_R_ADDR10;
                        res0.request_start = 1'b1;
                    end
                end
                // 10-bit header sent
                if (item.event_flags[i2cmts_pkg::EV_ADD10]) begin
                    if (ph == i2cmts_pkg::PH_T_START) begin
                        ph = i2cmts_pkg::PH_T_HDR10;
                        res0.send_valid = 1'b1;
                        res0.send_byte  = tgt[7:0];
                    end else if (ph == i2cmts_pkg::PH_R_START) begin
                        ph = i2cmts_pkg::PH_R_HDR10;
                        res0.send_valid = 1'b1;
                        res0.send_byte  = tgt[7:0];
                    end
                end
                // tx empty
                if (item.event_flags[i2cmts_pkg::EV_TXE] && ph == i2cmts_pkg::PH_T_DATA) begin
                    if (bc < len) begin
                        bc = bc + LW'(1);
                        res0.send_valid = 1'b1;
                        res0.send_byte  = item.data_byte;
                    end
                    if (bc == len) begin
                        res0.buffer_irq_control = i2cmts_pkg::CTL_CLR;
                        if (item.event_flags[i2cmts_pkg::EV_BTF]) begin
                            res0.request_stop = 1'b1;
                            res0.done_res     = 1'b1;
                            ph = i2cmts_pkg::PH_IDLE;
                        end
                    end
                end
                // rx full
                if (item.event_flags[i2cmts_pkg::EV_RXNE] && ph == i2cmts_pkg::PH_R_DATA) begin
                    if (len == LW'(1)) begin
                        res0.request_stop   = 1'b1;
                        res0.received_valid = 1'b1;
                        res0.received_byte  = item.data_byte;
                        res0.ack_control    = i2cmts_pkg::CTL_SET;
                        res0.done_res       = 1'b1;
                        ph = i2cmts_pkg::PH_IDLE;
                    end else if (len == LW'(2)) begin
                        bc = bc + LW'(1);
                        if (bc == LW'(1)) begin
                            res0.request_stop   = 1'b1;
                            res0.received_valid = 1'b1;
                            res0.received_byte  = item.data_byte;
                        end else if (bc == LW'(2)) begin
                            res0.received_valid = 1'b1;
                            res0.received_byte  = item.data_byte;
                            res0.ack_control    = i2cmts_pkg::CTL_SET;
                            res0.pos_control    = i2cmts_pkg::CTL_CLR;
                            res0.done_res       = 1'b1;
                            ph = i2cmts_pkg::PH_IDLE;
                        end
                    end else if (len > LW'(2)) begin
                        if (CW'(bc) + CW'(4) <= CW'(len)) begin
                            bc = bc + LW'(1);
                            res0.received_valid = 1'b1;
                            res0.received_byte  = item.data_byte;
                        end else if (bc == len - LW'(3)) begin
                            res0.buffer_irq_control = i2cmts_pkg::CTL_CLR;
                            if (item.event_flags[i2cmts_pkg::EV_BTF]) begin
                                res0.ack_control    = i2cmts_pkg::CTL_CLR;
                                bc = bc + LW'(1);
                                res0.received_valid = 1'b1;
                                res0.received_byte  = item.data_byte;
                            end
                        end else if (bc == len - LW'(2)) begin
                            if (item.event_flags[i2cmts_pkg::EV_BTF]) begin
                                // last two bytes come out of the shift and data regs
                                res0.request_stop   = 1'b1;
                                bc = bc + LW'(2);
                                res0.received_valid = 1'b1;
                                res0.received_byte  = item.data_byte;
                                res0.ack_control    = i2cmts_pkg::CTL_SET;
                                ph = i2cmts_pkg::PH_IDLE;
                                res1.received_valid = 1'b1;
                                res1.received_byte  = item.second_data_byte;
                                res1.done_res       = 1'b1;
                                two_res = 1'b1;
                            end
                        end
                    end
                end
            end
            i2cmts_pkg::OP_ERROR_EVENT: begin
                if (item.error_flags[i2cmts_pkg::ER_BUS] && ph != i2cmts_pkg::PH_IDLE) begin
                    err = err | i2cmts_pkg::ES_BUS;
                    res0.done_res = 1'b1;
                    ph = i2cmts_pkg::PH_IDLE;
                end
                if (item.error_flags[i2cmts_pkg::ER_AF]) begin
                    if (ph == i2cmts_pkg::PH_T_DATA) begin
                        err = err | i2cmts_pkg::ES_DATA_NACK;
                        res0.request_stop = 1'b1;
                        res0.done_res     = 1'b1;
                        ph = i2cmts_pkg::PH_IDLE;
                    end else if (ph != i2cmts_pkg::PH_IDLE) begin
                        err = err | i2cmts_pkg::ES_ADDR_NACK;
                        res0.request_stop = 1'b1;
                        res0.done_res     = 1'b1;
                        ph = i2cmts_pkg::PH_IDLE;
                    end
                end
                if (item.error_flags[i2cmts_pkg::ER_ARLO] && ph != i2cmts_pkg::PH_IDLE) begin
                    err = err | i2cmts_pkg::ES_ARLO;
                    res0.done_res = 1'b1;
                    ph = i2cmts_pkg::PH_IDLE;
                end
            end
            i2cmts_pkg::OP_CLEAR_ERROR: begin
                err = 4'd0;
            end
            default: begin
            end
        endcase

        // a clear reports the bits it removed
        status = (item.operation == i2cmts_pkg::OP_CLEAR_ERROR) ? ctx_cur.error_bits : err;
        res0.error_status = status;
        res1.error_status = status;
        res0.last = !two_res;
        res1.last = 1'b1;

        ctx_nxt.phase             = ph;
        ctx_nxt.target            = tgt;
        ctx_nxt.target_is_ten_bit = ten;
        ctx_nxt.error_bits        = err;
        length_nxt = len;
        count_nxt  = bc;
    end

endmodule

// ===== design/i2cmts_out_fifo.sv =====
// Two-entry result queue; one or two in per cycle, one out on out_ready.
module i2cmts_out_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push0,
    input  logic                    push1,
    input  i2cmts_pkg::res_t        din0,
    input  i2cmts_pkg::res_t        din1,
    output logic                    out_valid,
    input  logic                    out_ready,
    output i2cmts_pkg::res_t        dout,
    output i2cmts_pkg::fifo_stat_t  stat
);

    i2cmts_pkg::res_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign dout      = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg ^ (push0 ^ push1);
    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign count_next  = count_reg - {1'b0, pop} + {1'b0, push0} + {1'b0, push1};

    assign stat.count = count_reg;
    assign stat.space = i2cmts_pkg::OUT_DEPTH - count_reg + {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_ptr_reg] <= din0;
        end
        if (push1) begin
            mem_reg[~wr_ptr_reg] <= din1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/i2c_master_transfer_sequencer.sv =====
// I2C master transfer sequencer. Each request on the s_ channel (start write,
// start read, bus event, error event, clear error) is captured in an input
// register, evaluated combinationally against the transfer state, and its
// results are pushed into a two-entry result queue that drives the m_ channel.
// A new request can be taken every cycle while the queue has room; its results
// pass through the input register and then the queue before the m_ channel.
// Every request yields one result except the final two-byte read of a transfer
// longer than two bytes, which yields two (the second carries last=1). A
// request is retired only when the queue has room for all its results: with
// m_ready held high the input stalls only when a two-result read finds the
// queue holding two results; with m_ready low, once the queue lacks room. The
// result queue sets throughput: one result per cycle while m_ready is high.
// cfg_we/cfg_wdata write hold_errors (when set, pending error bits refuse a new
// start instead of being cleared by it); write it only while the block is idle.
module i2c_master_transfer_sequencer #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [9:0]  s_target_address,
    input  logic        s_ten_bit_address,
    input  logic [15:0] s_transfer_length,
    input  logic [5:0]  s_event_flags,
    input  logic [2:0]  s_error_flags,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_second_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_valid,
    output logic [7:0]  m_send_byte,
    output logic        m_request_start,
    output logic        m_request_stop,
    output logic [1:0]  m_ack_control,
    output logic [1:0]  m_pos_control,
    output logic [1:0]  m_buffer_irq_control,
    output logic        m_received_valid,
    output logic [7:0]  m_received_byte,
    output logic        m_done_res,
    output logic [3:0]  m_error_status,
    output logic        m_last
);

    // configuration
    logic hold_errors_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_errors_reg <= 1'b0;
        end else if (cfg_we) begin
            hold_errors_reg <= cfg_wdata;
        end
    end

    // input register
    logic               in_valid_reg, in_valid_next;
    i2cmts_pkg::item_t  in_item_reg;
    logic               consume;
    logic               s_accept;

    assign s_ready  = !in_valid_reg || consume;
    assign s_accept = s_valid && s_ready;
    assign in_valid_next = s_accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.operation        <= s_operation;
            in_item_reg.target_address   <= s_target_address;
            in_item_reg.ten_bit_address  <= s_ten_bit_address;
            in_item_reg.transfer_length  <= s_transfer_length;
            in_item_reg.event_flags      <= s_event_flags;
            in_item_reg.error_flags      <= s_error_flags;
            in_item_reg.data_byte        <= s_data_byte;
            in_item_reg.second_data_byte <= s_second_data_byte;
        end
    end

    // transfer state
    i2cmts_pkg::ctx_t          ctx_reg, ctx_next;
    logic [LENGTH_WIDTH-1:0]   length_reg, length_next;
    logic [LENGTH_WIDTH-1:0]   count_reg, count_next;
    i2cmts_pkg::res_t          res0, res1;
    logic                      two_res;

    i2cmts_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .item         (in_item_reg),
        .hold_errors  (hold_errors_reg),
        .ctx_cur      (ctx_reg),
        .length_cur   (length_reg),
        .count_cur    (count_reg),
        .ctx_nxt      (ctx_next),
        .length_nxt   (length_next),
        .count_nxt    (count_next),
        .res0         (res0),
        .res1         (res1),
        .two_res      (two_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.phase             <= i2cmts_pkg::PH_IDLE;
            ctx_reg.target            <= 10'd0;
            ctx_reg.target_is_ten_bit <= 1'b0;
            ctx_reg.error_bits        <= 4'd0;
            length_reg                <= '0;
            count_reg                 <= '0;
        end else if (consume) begin
            ctx_reg    <= ctx_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // result queue; a request is retired only when all its results fit
    i2cmts_pkg::res_t        head;
    i2cmts_pkg::fifo_stat_t  fifo_stat;

    assign consume = in_valid_reg && (fifo_stat.space >= (two_res ? 2'd2 : 2'd1));

    i2cmts_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (consume),
        .push1     (consume && two_res),
        .din0      (res0),
        .din1      (res1),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .dout      (head),
        .stat      (fifo_stat)
    );

    assign m_send_valid         = head.send_valid;
    assign m_send_byte          = head.send_byte;
    assign m_request_start      = head.request_start;
    assign m_request_stop       = head.request_stop;
    assign m_ack_control        = head.ack_control;
    assign m_pos_control        = head.pos_control;
    assign m_buffer_irq_control = head.buffer_irq_control;
    assign m_received_valid     = head.received_valid;
    assign m_received_byte      = head.received_byte;
    assign m_done_res           = head.done_res;
    assign m_error_status       = head.error_status;
    assign m_last               = head.last;

`ifndef ASSERT_OFF
    // a held request is neither dropped nor altered while the queue lacks room for it
    a_hold_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held request lost or changed");

    // the two-result read always ends the transfer
    a_pair_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && two_res) |=> (ctx_reg.phase == i2cmts_pkg::PH_IDLE))
        else $error("two-result read did not return to idle");

    // a non-last result always has its partner queued behind it
    a_pair_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (fifo_stat.count == 2'd2))
        else $error("first of a result pair without its partner");
`endif

endmodule
